// File: rtl/ucs_pkg.sv
package ucs_pkg;

  localparam int unsigned CpW     = 21;
  localparam int unsigned LenW    = 3;
  localparam int unsigned TabW    = 7;
  localparam int unsigned LineW   = 24;
  localparam int unsigned ColW    = 16;
  localparam int unsigned OffW    = 32;

  localparam logic [TabW-1:0] TabReset = 7'd4;
  localparam logic [TabW-1:0] TabMax   = 7'd64;

  // event queue between decoder and position tracker, power of two
  localparam int unsigned QueueDepth = 4;

  // remainder bits resolved per cycle while stepping to a tab stop
  localparam int unsigned RemBitsPerCycle = 4;

  localparam logic [7:0] ByteNul = 8'h00;
  localparam logic [7:0] ByteLf  = 8'h0a;
  localparam logic [7:0] ByteCr  = 8'h0d;
  localparam logic [7:0] BomB0   = 8'hef;
  localparam logic [7:0] BomB1   = 8'hbb;
  localparam logic [7:0] BomB2   = 8'hbf;

  typedef enum logic [2:0] {
    ClsOther   = 3'd0,
    ClsSpace   = 3'd1,
    ClsTab     = 3'd2,
    ClsNewline = 3'd3,
    ClsEnd     = 3'd4,
    ClsError   = 3'd5
  } cls_e;

  // one decoded character (or an offset-only skip for a dropped BOM)
  typedef struct packed {
    logic [CpW-1:0]  cp;
    logic [LenW-1:0] len;
    cls_e            cls;
    logic            skip;
    logic            last;
  } event_t;

  typedef struct packed {
    logic [1:0] cnt;
    event_t     ev0;
    event_t     ev1;
  } push_t;

  function automatic cls_e classify(input logic [CpW-1:0] cp);
    cls_e c;
    case (cp)
      21'h000009: c = ClsTab;
      21'h000020, 21'h00002c, 21'h0000a0, 21'h001680,
      21'h00202f, 21'h00205f, 21'h003000: c = ClsSpace;
      21'h00000a, 21'h00000b, 21'h00000c, 21'h00000d,
      21'h000085, 21'h002028, 21'h002029: c = ClsNewline;
      default: begin
        if (cp >= 21'h002000 && cp <= 21'h00200a) c = ClsSpace;
        else c = ClsOther;
      end
    endcase
    return c;
  endfunction

  function automatic event_t mk_evt(input logic [CpW-1:0] cp, input logic [LenW-1:0] len,
                                    input cls_e cls, input logic skip);
    event_t e;
    e.cp   = cp;
    e.len  = len;
    e.cls  = cls;
    e.skip = skip;
    e.last = 1'b0;
    return e;
  endfunction

  function automatic event_t mk_char(input logic [CpW-1:0] cp, input logic [LenW-1:0] len);
    return mk_evt(cp, len, classify(cp), 1'b0);
  endfunction

endpackage

// File: rtl/ucs_if.sv
interface ucs_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_input;

  modport source (output valid, output data_byte, output end_of_input, input ready);
  modport sink   (input valid, input data_byte, input end_of_input, output ready);
endinterface

interface ucs_char_if;
  logic        valid;
  logic        ready;
  logic [20:0] code_point;
  logic [2:0]  char_length;
  logic [2:0]  char_class;
  logic [23:0] line_number;
  logic [15:0] column_number;
  logic [31:0] byte_offset;
  logic        last_of_run;

  modport source (output valid, output code_point, output char_length, output char_class,
                  output line_number, output column_number, output byte_offset,
                  output last_of_run, input ready);
  modport sink   (input valid, input code_point, input char_length, input char_class,
                  input line_number, input column_number, input byte_offset,
                  input last_of_run, output ready);
endinterface

// File: rtl/ucs_front.sv
module ucs_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  ucs_byte_if.sink           in_bus,
  input  logic               space_ok_i,
  output ucs_pkg::push_t     push_o
);

  logic [1:0]                 pend_q, pend_d;
  logic [ucs_pkg::CpW-1:0]    part_q, part_d;
  logic [ucs_pkg::LenW-1:0]   seq_q, seq_d;
  logic                       held_q, held_d;
  logic                       start_q, start_d;
  logic                       err_q, err_d;
  logic                       bom_q, bom_d;

  logic                       accept;
  logic [7:0]                 in_byte;

  assign in_bus.ready = space_ok_i;
  assign accept       = in_bus.valid && in_bus.ready;
  assign in_byte      = in_bus.data_byte;

  always_comb begin
    ucs_pkg::event_t         ev_cr;
    ucs_pkg::event_t         ev_main;
    logic                    has_cr;
    logic                    has_main;
    logic                    handled;
    logic                    bom_nx;
    logic [ucs_pkg::CpW-1:0] part_nx;

    pend_d   = pend_q;
    part_d   = part_q;
    seq_d    = seq_q;
    held_d   = held_q;
    start_d  = start_q;
    err_d    = err_q;
    bom_d    = bom_q;
    ev_cr    = ucs_pkg::mk_char(ucs_pkg::CpW'(ucs_pkg::ByteCr), 3'd1);
    ev_main  = '0;
    has_cr   = 1'b0;
    has_main = 1'b0;
    handled  = 1'b0;
    bom_nx   = 1'b0;
    part_nx  = {part_q[ucs_pkg::CpW-7:0], in_byte[5:0]};

    if (accept && !err_q) begin
      if (in_bus.end_of_input) begin
        start_d = 1'b0;
        if (held_q) begin
          held_d = 1'b0;
          has_cr = 1'b1;
        end
        has_main = 1'b1;
        if (pend_q != 2'd0) begin
          ev_main = ucs_pkg::mk_evt('0, 3'd0, ucs_pkg::ClsError, 1'b0);
          err_d   = 1'b1;
          pend_d  = 2'd0;
          held_d  = 1'b0;
          bom_d   = 1'b0;
        end else begin
          ev_main = ucs_pkg::mk_evt('0, 3'd0, ucs_pkg::ClsEnd, 1'b0);
        end
      end else begin
        if (held_q) begin
          held_d = 1'b0;
          has_cr = 1'b1;
          if (in_byte == ucs_pkg::ByteLf) begin
            // CR LF merges into one two-byte newline
            ev_cr   = ucs_pkg::mk_char(ucs_pkg::CpW'(ucs_pkg::ByteCr), 3'd2);
            handled = 1'b1;
          end
        end
        if (!handled && pend_q != 2'd0) begin
          bom_nx = bom_q &&
                   (in_byte == ((pend_q == 2'd2) ? ucs_pkg::BomB1 : ucs_pkg::BomB2));
          part_d = part_nx;
          pend_d = pend_q - 2'd1;
          bom_d  = bom_nx;
          if (pend_q == 2'd1) begin
            has_main = 1'b1;
            bom_d    = 1'b0;
            if (bom_nx && seq_q == 3'd3) begin
              ev_main = ucs_pkg::mk_evt('0, 3'd3, ucs_pkg::ClsOther, 1'b1);
            end else begin
              ev_main = ucs_pkg::mk_char(part_nx, seq_q);
            end
          end
        end else if (!handled) begin
          start_d = 1'b0;
          if (!in_byte[7]) begin
            if (in_byte == ucs_pkg::ByteCr) begin
              held_d = 1'b1;
            end else if (in_byte == ucs_pkg::ByteNul) begin
              has_main = 1'b1;
              ev_main  = ucs_pkg::mk_evt('0, 3'd1, ucs_pkg::ClsEnd, 1'b0);
            end else begin
              has_main = 1'b1;
              ev_main  = ucs_pkg::mk_char({13'd0, in_byte}, 3'd1);
            end
          end else if (in_byte[7:5] == 3'b110) begin
            part_d = {16'd0, in_byte[4:0]};
            seq_d  = 3'd2;
            pend_d = 2'd1;
          end else if (in_byte[7:4] == 4'b1110) begin
            part_d = {17'd0, in_byte[3:0]};
            seq_d  = 3'd3;
            pend_d = 2'd2;
            bom_d  = start_q && (in_byte == ucs_pkg::BomB0);
          end else if (in_byte[7:3] == 5'b11110) begin
            part_d = {18'd0, in_byte[2:0]};
            seq_d  = 3'd4;
            pend_d = 2'd3;
          end else begin
            has_main = 1'b1;
            ev_main  = ucs_pkg::mk_evt('0, 3'd0, ucs_pkg::ClsError, 1'b0);
            err_d    = 1'b1;
            pend_d   = 2'd0;
            held_d   = 1'b0;
            bom_d    = 1'b0;
          end
        end
      end
    end

    push_o = '0;
    if (has_cr) begin
      push_o.ev0      = ev_cr;
      push_o.ev1      = ev_main;
      push_o.cnt      = has_main ? 2'd2 : 2'd1;
      push_o.ev0.last = !has_main;
      push_o.ev1.last = has_main;
    end else if (has_main) begin
      push_o.ev0      = ev_main;
      push_o.ev0.last = 1'b1;
      push_o.cnt      = 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q  <= 2'd0;
      part_q  <= '0;
      seq_q   <= '0;
      held_q  <= 1'b0;
      start_q <= 1'b1;
      err_q   <= 1'b0;
      bom_q   <= 1'b0;
    end else begin
      pend_q  <= pend_d;
      part_q  <= part_d;
      seq_q   <= seq_d;
      held_q  <= held_d;
      start_q <= start_d;
      err_q   <= err_d;
      bom_q   <= bom_d;
    end
  end

endmodule

// File: rtl/ucs_queue.sv
module ucs_queue #(
  parameter int unsigned Depth = ucs_pkg::QueueDepth
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  ucs_pkg::push_t  push_i,
  output logic            space_ok_o,
  input  logic            pop_i,
  output ucs_pkg::event_t head_o,
  output logic            head_valid_o
);

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);

  ucs_pkg::event_t mem_q [Depth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;
  logic [PtrW-1:0] wr_nx;

  assign wr_nx        = wr_q + PtrW'(1);
  // room for the two transfers one input byte can cause
  assign space_ok_o   = cnt_q <= CntW'(Depth - 2);
  assign head_valid_o = cnt_q != '0;
  assign head_o       = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i.cnt != 2'd0) mem_q[wr_q] <= push_i.ev0;
    if (push_i.cnt == 2'd2) mem_q[wr_nx] <= push_i.ev1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_q + PtrW'(push_i.cnt);
      rd_q  <= rd_q + PtrW'(pop_i);
      cnt_q <= cnt_q + CntW'(push_i.cnt) - CntW'(pop_i);
    end
  end

endmodule

// File: rtl/ucs_back.sv
module ucs_back (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [ucs_pkg::TabW-1:0]   cfg_data_i,
  input  ucs_pkg::event_t            head_i,
  input  logic                       head_valid_i,
  output logic                       pop_o,
  ucs_char_if.source                 out_bus
);

  localparam int unsigned ColW   = ucs_pkg::ColW;
  localparam int unsigned LineW  = ucs_pkg::LineW;
  localparam int unsigned OffW   = ucs_pkg::OffW;
  localparam int unsigned TabW   = ucs_pkg::TabW;
  localparam int unsigned RemB   = ucs_pkg::RemBitsPerCycle;
  localparam int unsigned Steps  = ColW / RemB;
  localparam int unsigned StepW  = (Steps > 1) ? $clog2(Steps) : 1;

  typedef enum logic {StRun, StTab} state_e;

  state_e                   state_q;
  logic [TabW-1:0]          tab_q;
  logic [LineW-1:0]         line_q;
  logic [ColW-1:0]          col_q;
  logic [OffW-1:0]          off_q;
  logic [ColW-1:0]          dx_q;
  logic [TabW-1:0]          rem_q;
  logic [TabW-1:0]          tdiv_q;
  logic [StepW-1:0]         step_q;

  logic                     out_valid_q;
  logic [ucs_pkg::CpW-1:0]  cp_q;
  logic [ucs_pkg::LenW-1:0] len_q;
  logic [2:0]               cls_q;
  logic [LineW-1:0]         oline_q;
  logic [ColW-1:0]          ocol_q;
  logic [OffW-1:0]          ooff_q;
  logic                     last_q;

  logic [TabW-1:0]          t_eff;
  logic [ColW-1:0]          col_inc;
  logic [LineW-1:0]         line_inc;
  logic [OffW-1:0]          off_add;
  logic [OffW:0]            off_sum;
  logic [ColW-1:0]          dx_d;
  logic [TabW-1:0]          rem_d;
  logic [ColW:0]            tab_sum;
  logic [ColW-1:0]          tab_col;

  assign t_eff = (tab_q == '0)            ? TabW'(1) :
                 (tab_q > ucs_pkg::TabMax) ? ucs_pkg::TabMax : tab_q;

  assign col_inc  = (col_q == '1)  ? col_q  : col_q + ColW'(1);
  assign line_inc = (line_q == '1) ? line_q : line_q + LineW'(1);
  assign off_sum  = {1'b0, off_q} + (OffW + 1)'(head_i.len);
  assign off_add  = off_sum[OffW] ? '1 : off_sum[OffW-1:0];

  // restoring remainder of (column - 1) by the tab length, a few bits a cycle
  always_comb begin
    logic [TabW-1:0] r;
    logic [ColW-1:0] x;
    r = rem_q;
    x = dx_q;
    for (int i = 0; i < RemB; i++) begin
      r = {r[TabW-2:0], x[ColW-1]};
      x = {x[ColW-2:0], 1'b0};
      if (r >= tdiv_q) r = r - tdiv_q;
    end
    rem_d = r;
    dx_d  = x;
  end

  assign tab_sum = {1'b0, col_q} + (ColW + 1)'(tdiv_q - rem_d);
  assign tab_col = tab_sum[ColW] ? '1 : tab_sum[ColW-1:0];

  assign pop_o = (state_q == StRun) && head_valid_i &&
                 (head_i.skip || !out_valid_q || out_bus.ready);

  assign out_bus.valid         = out_valid_q;
  assign out_bus.code_point    = cp_q;
  assign out_bus.char_length   = len_q;
  assign out_bus.char_class    = cls_q;
  assign out_bus.line_number   = oline_q;
  assign out_bus.column_number = ocol_q;
  assign out_bus.byte_offset   = ooff_q;
  assign out_bus.last_of_run   = last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StRun;
      tab_q       <= ucs_pkg::TabReset;
      line_q      <= LineW'(1);
      col_q       <= ColW'(1);
      off_q       <= '0;
      out_valid_q <= 1'b0;
      dx_q        <= '0;
      rem_q       <= '0;
      tdiv_q      <= TabW'(1);
      step_q      <= '0;
      cp_q        <= '0;
      len_q       <= '0;
      cls_q       <= '0;
      oline_q     <= '0;
      ocol_q      <= '0;
      ooff_q      <= '0;
      last_q      <= 1'b0;
    end else begin
      if (cfg_we_i) tab_q <= cfg_data_i;
      out_valid_q <= (pop_o && !head_i.skip) || (out_valid_q && !out_bus.ready);
      if (pop_o && !head_i.skip) begin
        cp_q    <= head_i.cp;
        len_q   <= head_i.len;
        cls_q   <= 3'(head_i.cls);
        oline_q <= line_q;
        ocol_q  <= col_q;
        ooff_q  <= off_q;
        last_q  <= head_i.last;
      end

      case (state_q)
        StRun: begin
          if (pop_o) begin
            // error and end-of-input marker do not move the position; a NUL end marker does
            if (head_i.len != '0) begin
              off_q <= off_add;
              if (!head_i.skip) begin
                case (head_i.cls)
                  ucs_pkg::ClsNewline: begin
                    col_q  <= ColW'(1);
                    line_q <= line_inc;
                  end
                  ucs_pkg::ClsTab: begin
                    state_q <= StTab;
                    dx_q    <= col_q - ColW'(1);
                    rem_q   <= '0;
                    tdiv_q  <= t_eff;
                    step_q  <= '0;
                  end
                  default: col_q <= col_inc;
                endcase
              end
            end
          end
        end
        StTab: begin
          dx_q   <= dx_d;
          rem_q  <= rem_d;
          step_q <= step_q + StepW'(1);
          if (step_q == StepW'(Steps - 1)) begin
            col_q   <= tab_col;
            state_q <= StRun;
          end
        end
        default: state_q <= StRun;
      endcase
    end
  end

endmodule

// File: rtl/utf8_char_scanner.sv
// UTF-8 character scanner: takes one byte (or an end marker) per transfer and
// returns one result per decoded character with its code point, length, class
// and the line, column and byte offset where it starts. A decoder front end
// feeds a 4-entry event queue, drained by a position tracker with a registered
// output, so the input keeps moving while a result waits. Throughput is one
// byte per cycle while the queue has room; a tab holds the tracker while the
// tab-stop remainder is resolved 4 bits per cycle, and a held CR followed by a
// non-LF input that makes a result of its own yields two results from one
// input. A bad lead byte or an end mid-sequence reports one error result and
// then no further results until reset. Write tab_length only while the block is idle.
module utf8_char_scanner #(
  parameter int unsigned QueueDepth = ucs_pkg::QueueDepth
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  ucs_byte_if.sink                 in_bus,
  ucs_char_if.source               out_bus,
  input  logic                     cfg_we_i,
  input  logic [ucs_pkg::TabW-1:0] cfg_data_i
);

  ucs_pkg::push_t  push;
  ucs_pkg::event_t head;
  logic            space_ok;
  logic            head_valid;
  logic            pop;

  ucs_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_bus     (in_bus),
    .space_ok_i (space_ok),
    .push_o     (push)
  );

  ucs_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .space_ok_o   (space_ok),
    .pop_i        (pop),
    .head_o       (head),
    .head_valid_o (head_valid)
  );

  ucs_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_data_i   (cfg_data_i),
    .head_i       (head),
    .head_valid_i (head_valid),
    .pop_o        (pop),
    .out_bus      (out_bus)
  );

endmodule
